/* sv/psgsf_pkg.sv */
// Shared types, constants and codes of the sound chip register shadow.
package psgsf_pkg;

    // Register slot layout.
    localparam int SLOT_COUNT   = 27;
    localparam int SLOT_W       = 5;
    localparam int SHAPE_SLOT   = 13;
    localparam int MIXER_SLOT   = 7;
    localparam int VOLUME_SLOT  = 8;
    localparam int DUTY_SLOT    = 22;
    localparam int BANKB_FIRST  = 16;
    localparam int BANKB_COUNT  = SLOT_COUNT - BANKB_FIRST;
    localparam int BANKA_COUNT  = SHAPE_SLOT + 1;
    localparam int CHAN_COUNT   = 3;

    // Emission order: bank switch, bank B slots, switch back, bank A slots.
    localparam int SEQ_LEN      = BANKA_COUNT + BANKB_COUNT + 2;
    localparam int POS_W        = 5;
    localparam int POS_HEADER   = 0;
    localparam int POS_FOOTER   = BANKB_COUNT + 1;

    // Mode nibble codes and register values.
    localparam logic [3:0] MODE_BANK_B = 4'hB;
    localparam logic [3:0] MODE_BANK_A = 4'hA;
    localparam logic [7:0] DUTY_FIX    = 8'h08;

    // Command queue between the front and the back.
    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int QPTR_W          = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
    localparam int QCNT_W          = $clog2(CMD_QUEUE_DEPTH + 1);

    // Request codes on the input channel.
    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_UPDATE = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    // Result kinds.
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_BUS  = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_UPDATE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0] req_type;
        logic       direct;
        logic [4:0] reg_index;
        logic [7:0] write_data;
    } t_in;

    typedef struct packed {
        logic       kind;
        logic [3:0] bus_addr;
        logic [7:0] out_data;
        logic       last;
    } t_out;

    // Classified request as it waits in the queue.
    typedef struct packed {
        t_op        op;
        logic       no_slot;
        logic       direct;
        logic [4:0] reg_index;
        logic [7:0] data;
    } t_cmd;

endpackage

/* sv/psgsf_fifo.sv */
// Short command queue between the request front end and the execution back end.
module psgsf_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  psgsf_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output psgsf_pkg::t_cmd o_cmd,
    output logic            o_empty
);

    psgsf_pkg::t_cmd                    r_mem [psgsf_pkg::CMD_QUEUE_DEPTH];
    logic [psgsf_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [psgsf_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [psgsf_pkg::QCNT_W-1:0]       r_count;
    logic [psgsf_pkg::QPTR_W-1:0]       n_wr_ptr;
    logic [psgsf_pkg::QPTR_W-1:0]       n_rd_ptr;
    logic [psgsf_pkg::QCNT_W-1:0]       n_count;
    logic                               do_push;
    logic                               do_pop;

    assign o_full  = (r_count == psgsf_pkg::QCNT_W'(psgsf_pkg::CMD_QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer wrap and occupancy.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == psgsf_pkg::QPTR_W'(psgsf_pkg::CMD_QUEUE_DEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == psgsf_pkg::QPTR_W'(psgsf_pkg::CMD_QUEUE_DEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* sv/psgsf_front.sv */
// Request front end: accepts input beats and classifies them into queued commands.
module psgsf_front (
    input  logic            i_in_valid,
    input  psgsf_pkg::t_in  i_in_data,
    output logic            o_in_stall,
    input  logic            i_fifo_full,
    output logic            o_push,
    output psgsf_pkg::t_cmd o_cmd
);

    // A beat is taken whenever the queue has room.
    assign o_in_stall = i_fifo_full;
    assign o_push     = i_in_valid && !i_fifo_full;

    // Decode the request code and flag banked indexes that name no slot.
    always_comb begin
        o_cmd.no_slot   = !i_in_data.direct && i_in_data.reg_index[4];
        o_cmd.direct    = i_in_data.direct;
        o_cmd.reg_index = i_in_data.reg_index;
        o_cmd.data      = i_in_data.write_data;
        unique case (i_in_data.req_type)
            psgsf_pkg::REQ_WRITE:  o_cmd.op = psgsf_pkg::OP_WRITE;
            psgsf_pkg::REQ_READ:   o_cmd.op = psgsf_pkg::OP_READ;
            psgsf_pkg::REQ_UPDATE: o_cmd.op = psgsf_pkg::OP_UPDATE;
            psgsf_pkg::REQ_CLEAR:  o_cmd.op = psgsf_pkg::OP_CLEAR;
            default:               o_cmd.op = psgsf_pkg::OP_CLEAR;
        endcase
    end

endmodule

/* sv/psgsf_back.sv */
// Execution back end: shadow registers, change mask and the flush sequencer.
module psgsf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_chip_is_extended,
    input  logic            i_cmd_empty,
    input  psgsf_pkg::t_cmd i_cmd,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output psgsf_pkg::t_out o_out_data
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } t_state;

    t_state                                r_state;
    t_state                                n_state;
    logic [7:0]                            r_shadow [psgsf_pkg::SLOT_COUNT];
    logic [7:0]                            n_shadow [psgsf_pkg::SLOT_COUNT];
    logic [3:0]                            r_mode;
    logic [3:0]                            n_mode;
    logic [psgsf_pkg::SLOT_COUNT-1:0]      r_mask;
    logic [psgsf_pkg::SLOT_COUNT-1:0]      n_mask;
    logic [psgsf_pkg::SEQ_LEN-1:0]         r_seq;
    logic [psgsf_pkg::SEQ_LEN-1:0]         n_seq;
    logic [psgsf_pkg::POS_W-1:0]           r_pos;
    logic [psgsf_pkg::POS_W-1:0]           n_pos;
    logic [psgsf_pkg::CHAN_COUNT-1:0]      r_fix;
    logic [psgsf_pkg::CHAN_COUNT-1:0]      n_fix;
    logic                                  r_out_valid;
    logic                                  n_out_valid;
    psgsf_pkg::t_out                       r_out;
    psgsf_pkg::t_out                       n_out;

    logic                                  out_free;
    logic [psgsf_pkg::SLOT_W-1:0]          cmd_slot;
    logic [psgsf_pkg::SLOT_W-1:0]          walk_slot;
    logic [psgsf_pkg::SLOT_W-1:0]          rd_slot;
    logic [7:0]                            rd_val;
    logic [3:0]                            shape;
    logic [psgsf_pkg::CHAN_COUNT-1:0]      fix;
    logic [psgsf_pkg::SLOT_COUNT-1:0]      alt;
    logic [psgsf_pkg::SLOT_COUNT-1:0]      marks;
    logic [psgsf_pkg::BANKB_COUNT-1:0]     bmarks;
    logic [psgsf_pkg::BANKA_COUNT-1:0]     amarks;
    logic                                  switched;
    logic [psgsf_pkg::SEQ_LEN-1:0]         seq;
    logic [psgsf_pkg::SEQ_LEN-1:0]         seq_left;
    logic [7:0]                            walk_data;
    logic [3:0]                            walk_addr;
    logic [1:0]                            duty_chan;
    logic                                  vol_bit;
    logic [7:0]                            mixer;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign shape       = r_shadow[psgsf_pkg::SHAPE_SLOT][3:0];
    assign mixer       = r_shadow[psgsf_pkg::MIXER_SLOT];

    // Banked indexes land in bank B while the mode nibble selects it.
    assign cmd_slot = i_cmd.direct ? i_cmd.reg_index
                    : ((r_mode == psgsf_pkg::MODE_BANK_B) ? {1'b1, i_cmd.reg_index[3:0]}
                                                          : i_cmd.reg_index);

    // Walk position to slot: bank B slots follow the header, bank A slots the footer.
    assign walk_slot = (r_pos < psgsf_pkg::POS_W'(psgsf_pkg::POS_FOOTER))
                     ? r_pos + psgsf_pkg::POS_W'(psgsf_pkg::BANKB_FIRST - 1)
                     : r_pos - psgsf_pkg::POS_W'(psgsf_pkg::POS_FOOTER + 1);

    // One shared read port on the shadow file.
    assign rd_slot = (r_state == ST_WALK) ? walk_slot : cmd_slot;
    assign rd_val  = (rd_slot < psgsf_pkg::SLOT_W'(psgsf_pkg::SLOT_COUNT))
                   ? r_shadow[rd_slot] : 8'h00;

    // Pure-envelope fix per channel and the slots that it alters.
    always_comb begin
        alt = '0;
        for (int i = 0; i < psgsf_pkg::CHAN_COUNT; i++) begin
            vol_bit = (r_mode != 4'h0) ? r_shadow[psgsf_pkg::VOLUME_SLOT + i][5]
                                       : r_shadow[psgsf_pkg::VOLUME_SLOT + i][4];
            fix[i]  = i_chip_is_extended && vol_bit && mixer[i] && mixer[3 + i];
            alt[2 * i]     = fix[i] && (r_shadow[2 * i] != 8'h00);
            alt[2 * i + 1] = fix[i] && (r_shadow[2 * i + 1] != 8'h00);
            alt[psgsf_pkg::DUTY_SLOT + i] =
                fix[i] && (r_shadow[psgsf_pkg::DUTY_SLOT + i] != psgsf_pkg::DUTY_FIX);
        end
        alt[psgsf_pkg::MIXER_SLOT] = |fix;
    end

    // Emission order of the flush, with the bank switch writes around bank B.
    always_comb begin
        marks    = r_mask | alt;
        bmarks   = (i_chip_is_extended && (r_mode != 4'h0))
                 ? marks[psgsf_pkg::SLOT_COUNT-1:psgsf_pkg::BANKB_FIRST] : '0;
        switched = |bmarks;
        amarks   = marks[psgsf_pkg::BANKA_COUNT-1:0];
        amarks[psgsf_pkg::SHAPE_SLOT] = amarks[psgsf_pkg::SHAPE_SLOT] && !switched;
        seq      = {amarks, switched, bmarks, switched};
    end

    // Beat contents for the current walk position.
    always_comb begin
        duty_chan = 2'(walk_slot - psgsf_pkg::SLOT_W'(psgsf_pkg::DUTY_SLOT));
        walk_addr = walk_slot[3:0];
        walk_data = rd_val;
        if (r_pos == psgsf_pkg::POS_W'(psgsf_pkg::POS_HEADER)) begin
            walk_addr = 4'(psgsf_pkg::SHAPE_SLOT);
            walk_data = {psgsf_pkg::MODE_BANK_B, shape};
        end else if (r_pos == psgsf_pkg::POS_W'(psgsf_pkg::POS_FOOTER)) begin
            walk_addr = 4'(psgsf_pkg::SHAPE_SLOT);
            walk_data = {psgsf_pkg::MODE_BANK_A, shape};
        end else if (walk_slot < psgsf_pkg::SLOT_W'(2 * psgsf_pkg::CHAN_COUNT)) begin
            if (r_fix[walk_slot[2:1]]) begin
                walk_data = 8'h00;
            end
        end else if (walk_slot == psgsf_pkg::SLOT_W'(psgsf_pkg::MIXER_SLOT)) begin
            walk_data = rd_val & ~{{(8 - psgsf_pkg::CHAN_COUNT){1'b0}}, r_fix};
        end else if (walk_slot == psgsf_pkg::SLOT_W'(psgsf_pkg::SHAPE_SLOT)) begin
            walk_data = {r_mode, rd_val[3:0]};
        end else if (walk_slot >= psgsf_pkg::SLOT_W'(psgsf_pkg::DUTY_SLOT)
                     && walk_slot < psgsf_pkg::SLOT_W'(psgsf_pkg::DUTY_SLOT
                                                       + psgsf_pkg::CHAN_COUNT)) begin
            if (r_fix[duty_chan]) begin
                walk_data = psgsf_pkg::DUTY_FIX;
            end
        end
    end

    assign seq_left = r_seq & ~(psgsf_pkg::SEQ_LEN'(1) << r_pos);

    // Command execution and the flush walk.
    always_comb begin
        n_state     = r_state;
        n_shadow    = r_shadow;
        n_mode      = r_mode;
        n_mask      = r_mask;
        n_seq       = r_seq;
        n_pos       = r_pos;
        n_fix       = r_fix;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_pop       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    unique case (i_cmd.op)
                        psgsf_pkg::OP_WRITE: begin
                            o_pop = 1'b1;
                            if (!i_cmd.no_slot) begin
                                if (cmd_slot[3:0] == 4'(psgsf_pkg::SHAPE_SLOT)) begin
                                    n_mode = i_cmd.data[7:4];
                                    n_shadow[psgsf_pkg::SHAPE_SLOT] = {4'h0, i_cmd.data[3:0]};
                                    n_mask[psgsf_pkg::SHAPE_SLOT]   = 1'b1;
                                end else if (cmd_slot
                                             < psgsf_pkg::SLOT_W'(psgsf_pkg::SLOT_COUNT)) begin
                                    // The two empty slots keep reading zero.
                                    if (cmd_slot != psgsf_pkg::SLOT_W'(psgsf_pkg::SHAPE_SLOT + 1)
                                        && cmd_slot
                                           != psgsf_pkg::SLOT_W'(psgsf_pkg::SHAPE_SLOT + 2)) begin
                                        n_shadow[cmd_slot] = i_cmd.data;
                                    end
                                    n_mask[cmd_slot] = 1'b1;
                                end
                            end
                        end
                        psgsf_pkg::OP_READ: begin
                            if (out_free) begin
                                o_pop          = 1'b1;
                                n_out_valid    = 1'b1;
                                n_out.kind     = psgsf_pkg::KIND_READ;
                                n_out.bus_addr = 4'h0;
                                n_out.last     = 1'b1;
                                if (i_cmd.no_slot) begin
                                    n_out.out_data = 8'h00;
                                end else if (cmd_slot[3:0] == 4'(psgsf_pkg::SHAPE_SLOT)) begin
                                    n_out.out_data = {r_mode, shape};
                                end else begin
                                    n_out.out_data = rd_val;
                                end
                            end
                        end
                        psgsf_pkg::OP_UPDATE: begin
                            o_pop = 1'b1;
                            if (r_mask != '0) begin
                                n_mask = '0;
                                n_fix  = fix;
                                n_seq  = seq;
                                n_pos  = '0;
                                if (seq != '0) begin
                                    n_state = ST_WALK;
                                end
                            end
                        end
                        psgsf_pkg::OP_CLEAR: begin
                            o_pop = 1'b1;
                            for (int s = 0; s < psgsf_pkg::SLOT_COUNT; s++) begin
                                n_shadow[s] = 8'h00;
                            end
                            n_mode = 4'h0;
                            n_mask = '0;
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (r_seq[r_pos]) begin
                    if (out_free) begin
                        n_out_valid    = 1'b1;
                        n_out.kind     = psgsf_pkg::KIND_BUS;
                        n_out.bus_addr = walk_addr;
                        n_out.out_data = walk_data;
                        n_out.last     = (seq_left == '0);
                        n_seq          = seq_left;
                        n_pos          = r_pos + 1'b1;
                        if (seq_left == '0) begin
                            n_state = ST_IDLE;
                        end
                    end
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and shadow state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= 4'h0;
            r_mask      <= '0;
            r_seq       <= '0;
            r_pos       <= '0;
            r_fix       <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < psgsf_pkg::SLOT_COUNT; s++) begin
                r_shadow[s] <= 8'h00;
            end
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_mask      <= n_mask;
            r_seq       <= n_seq;
            r_pos       <= n_pos;
            r_fix       <= n_fix;
            r_out_valid <= n_out_valid;
            r_shadow    <= n_shadow;
        end
    end

    // Output beat register.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

/* sv/psg_register_shadow_flusher.sv */
// Top level of the sound chip register shadow with bank switched flush.
//
//  Channel   Signals                               Beat
//  input     i_in_valid, o_in_stall, i_in_data     one request (write/read/update/clear)
//  output    o_out_valid, i_out_stall, o_out_data  read reply or chip bus write
//  config    i_cfg_we, i_cfg_wdata                 chip_is_extended bit
//
// A write or clear is executed in the back end from the queue head; a read also waits for
// a free output slot. An update first captures the emission order and then walks up to 27
// emission positions at one per cycle, holding while the output is stalled.
// Reset is synchronous and active low and zeroes the shadow, mode nibble and change mask.
// Input stall rises only when the two-entry command queue is full.
module psg_register_shadow_flusher (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  psgsf_pkg::t_in  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output psgsf_pkg::t_out o_out_data,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata
);

    logic            r_chip_is_extended;
    logic            fifo_full;
    logic            fifo_empty;
    logic            push;
    logic            pop;
    psgsf_pkg::t_cmd front_cmd;
    psgsf_pkg::t_cmd queue_cmd;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_is_extended <= 1'b0;
        end else if (i_cfg_we) begin
            r_chip_is_extended <= i_cfg_wdata;
        end
    end

    psgsf_front u_front (
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_fifo_full (fifo_full),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    psgsf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (fifo_full),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_empty (fifo_empty)
    );

    psgsf_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_chip_is_extended (r_chip_is_extended),
        .i_cmd_empty        (fifo_empty),
        .i_cmd              (queue_cmd),
        .o_pop              (pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_data         (o_out_data)
    );

endmodule
